### rtl/updown_hms_stopwatch_defines.svh
// ----------------------------------------------------------------------------
// updown_hms_stopwatch_defines
// assertion macros shared by the stopwatch checker
// ----------------------------------------------------------------------------
`ifndef UPDOWN_HMS_STOPWATCH_DEFINES_SVH
`define UPDOWN_HMS_STOPWATCH_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define UHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("uhs checker: same-cycle property failed");

// next-cycle implication, disabled while reset is asserted
`define UHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("uhs checker: next-cycle property failed");

`endif

### rtl/uhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhs_pkg
// types, event codes and limits of the up/down hh:mm:ss stopwatch
// ----------------------------------------------------------------------------
package uhs_pkg;

	// event codes on the input cmd field
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_RESET   = 3'd1;
	localparam logic [2:0] CMD_PAUSE   = 3'd2;
	localparam logic [2:0] CMD_RESUME  = 3'd3;
	localparam logic [2:0] CMD_BUTTONS = 3'd4;

	// button bit positions
	localparam int BTN_HDEC = 0;
	localparam int BTN_HINC = 1;
	localparam int BTN_MDEC = 2;
	localparam int BTN_MINC = 3;
	localparam int BTN_SDEC = 4;
	localparam int BTN_SINC = 5;
	localparam int BTN_MODE = 6;

	// time limits
	localparam int HOUR_LIMIT_DEF = 99;
	localparam int HOUR_LIMIT_MAX = 99;
	localparam logic [5:0] MS_MAX = 6'd59;

	// classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_NONE,
		OP_TICK,
		OP_CLEAR,
		OP_PAUSE,
		OP_RESUME,
		OP_BUTTONS
	} op_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [6:0] buttons;
	} in_item_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] buttons;
	} op_item_t;

	typedef struct packed {
		logic [6:0] hours_now;
		logic [5:0] minutes_now;
		logic [5:0] seconds_now;
		logic       counting_up;
		logic       is_running;
		logic       alarm_on;
	} res_item_t;

endpackage

### rtl/uhs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhs_fifo
// two-entry first-in first-out queue with full and empty flags
// ----------------------------------------------------------------------------
module uhs_fifo #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	// flags and handshakes
	assign full    = (count_q == (PW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
			if (do_push && !do_pop) count_q <= count_q + (PW+1)'(1);
			else if (do_pop && !do_push) count_q <= count_q - (PW+1)'(1);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

### rtl/uhs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhs_front
// accepts event items, decodes the event kind and queues the operation
// ----------------------------------------------------------------------------
module uhs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  uhs_pkg::in_item_t cmd_item,
	output logic              full,
	input  logic              pop,
	output uhs_pkg::op_item_t op_item,
	output logic              empty
);
	import uhs_pkg::*;

	op_item_t                  dec_item;
	logic [$bits(op_item_t)-1:0] q_rdata;

	// event decode, unused codes become a no-op
	always_comb begin
		dec_item.buttons = cmd_item.buttons;
		unique case (cmd_item.cmd)
			CMD_TICK:    dec_item.op = OP_TICK;
			CMD_RESET:   dec_item.op = OP_CLEAR;
			CMD_PAUSE:   dec_item.op = OP_PAUSE;
			CMD_RESUME:  dec_item.op = OP_RESUME;
			CMD_BUTTONS: dec_item.op = OP_BUTTONS;
			default:     dec_item.op = OP_NONE;
		endcase
	end

	// operation queue toward the back end
	uhs_fifo #(
		.WIDTH($bits(op_item_t))
	) u_op_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (dec_item),
		.full  (full),
		.pop   (pop),
		.rdata (q_rdata),
		.empty (empty)
	);

	assign op_item = op_item_t'(q_rdata);

endmodule

### rtl/uhs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhs_back
// time and flag state, carry and borrow update, result queue
// ----------------------------------------------------------------------------
module uhs_back #(
	parameter int HOUR_LIMIT = uhs_pkg::HOUR_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_empty,
	input  uhs_pkg::op_item_t  op_item,
	output logic               op_pop,
	output uhs_pkg::res_item_t result,
	output logic               empty,
	input  logic               pop
);
	import uhs_pkg::*;

	localparam logic [6:0] HOUR_MAX = 7'(HOUR_LIMIT);

	logic [6:0] hour_q;
	logic [5:0] minute_q;
	logic [5:0] second_q;
	logic       up_q;
	logic       run_q;
	logic       alarm_q;
	logic [6:0] marks_q;

	logic [6:0] h;
	logic [5:0] m;
	logic [5:0] s;
	logic       up;
	logic       run;
	logic       alarm;
	logic [6:0] marks;
	logic [6:0] b;

	res_item_t                    res_next;
	logic                         res_full;
	logic [$bits(res_item_t)-1:0] res_rdata;

	// take an operation whenever the result queue has room
	assign op_pop = !op_empty && !res_full;

	// next state for the operation at the head of the queue
	always_comb begin
		h     = hour_q;
		m     = minute_q;
		s     = second_q;
		up    = up_q;
		run   = run_q;
		alarm = alarm_q;
		marks = marks_q;
		b     = op_item.buttons;
		unique case (op_item.op)
			OP_TICK: begin
				if (run && up) begin
					alarm = 1'b0;
					if (s < MS_MAX) begin
						s = s + 6'd1;
					end else if (m < MS_MAX || h < HOUR_MAX) begin
						s = '0;
						if (m < MS_MAX) begin
							m = m + 6'd1;
						end else begin
							m = '0;
							h = h + 7'd1;
						end
					end
				end else if (run) begin
					if (h == '0 && m == '0 && s == '0) begin
						alarm = 1'b1;
					end else begin
						alarm = 1'b0;
						if (s != '0) begin
							s = s - 6'd1;
						end else begin
							s = MS_MAX;
							if (m != '0) begin
								m = m - 6'd1;
							end else begin
								m = MS_MAX;
								h = h - 7'd1;
							end
						end
					end
				end
			end
			OP_CLEAR: begin
				h     = '0;
				m     = '0;
				s     = '0;
				up    = 1'b1;
				alarm = 1'b0;
			end
			OP_PAUSE:  run = 1'b0;
			OP_RESUME: run = 1'b1;
			OP_BUTTONS: begin
				if (!run) begin
					// hours group
					if (b[BTN_HDEC]) begin
						if (h != '0 && !marks[BTN_HDEC]) begin
							h = h - 7'd1;
							marks[BTN_HDEC] = 1'b1;
						end
					end else if (b[BTN_HINC]) begin
						if (!marks[BTN_HINC]) begin
							if (h < HOUR_MAX) h = h + 7'd1;
							marks[BTN_HINC] = 1'b1;
						end
					end else begin
						marks[BTN_HDEC] = 1'b0;
						marks[BTN_HINC] = 1'b0;
					end
					// minutes group, carry into hours
					if (b[BTN_MDEC]) begin
						if (m != '0 && !marks[BTN_MDEC]) begin
							m = m - 6'd1;
							marks[BTN_MDEC] = 1'b1;
						end
					end else if (b[BTN_MINC]) begin
						if (!marks[BTN_MINC]) begin
							if (m < MS_MAX) begin
								m = m + 6'd1;
							end else if (h < HOUR_MAX) begin
								m = '0;
								h = h + 7'd1;
							end
							marks[BTN_MINC] = 1'b1;
						end
					end else begin
						marks[BTN_MDEC] = 1'b0;
						marks[BTN_MINC] = 1'b0;
					end
					// seconds group, carry through minutes into hours
					if (b[BTN_SDEC]) begin
						if (s != '0 && !marks[BTN_SDEC]) begin
							s = s - 6'd1;
							marks[BTN_SDEC] = 1'b1;
						end
					end else if (b[BTN_SINC]) begin
						if (!marks[BTN_SINC]) begin
							if (s < MS_MAX) begin
								s = s + 6'd1;
							end else if (m < MS_MAX || h < HOUR_MAX) begin
								s = '0;
								if (m < MS_MAX) begin
									m = m + 6'd1;
								end else begin
									m = '0;
									h = h + 7'd1;
								end
							end
							marks[BTN_SINC] = 1'b1;
						end
					end else begin
						marks[BTN_SDEC] = 1'b0;
						marks[BTN_SINC] = 1'b0;
					end
					// direction toggle once per press
					if (b[BTN_MODE]) begin
						if (!marks[BTN_MODE]) begin
							up = !up;
							marks[BTN_MODE] = 1'b1;
						end
					end else begin
						marks[BTN_MODE] = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			up_q     <= 1'b1;
			run_q    <= 1'b1;
			alarm_q  <= 1'b0;
			marks_q  <= '0;
		end else if (op_pop) begin
			hour_q   <= h;
			minute_q <= m;
			second_q <= s;
			up_q     <= up;
			run_q    <= run;
			alarm_q  <= alarm;
			marks_q  <= marks;
		end
	end

	// result item built from the updated state
	always_comb begin
		res_next.hours_now   = h;
		res_next.minutes_now = m;
		res_next.seconds_now = s;
		res_next.counting_up = up;
		res_next.is_running  = run;
		res_next.alarm_on    = alarm;
	end

	// result queue toward the consumer
	uhs_fifo #(
		.WIDTH($bits(res_item_t))
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (op_pop),
		.wdata (res_next),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign result = res_item_t'(res_rdata);

endmodule

### rtl/updown_hms_stopwatch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// updown_hms_stopwatch
// up/down hours:minutes:seconds stopwatch and countdown timer
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive cmd_item (cmd, buttons) and raise push; the item is
//   taken at a clock edge where push is high and full is low.
//   Result queue: while empty is low, result holds the state after the
//   oldest waiting item; raise pop to take it.
//   Every event item gives exactly one result item, in order.
//   An accepted item passes through the operation queue into the result queue.
//   Throughput: one item per cycle while the result queue has room, set by
//   the combinational back-end update and the hop through the operation queue.
//   When the consumer stalls, up to two results wait in the result queue
//   and two decoded items in the operation queue; full then rises and
//   stays high until results are popped again.
//   Reset (arst_n low): time 00:00:00, counting up, running, alarm and
//   press marks clear, both queues empty.
// ----------------------------------------------------------------------------
module updown_hms_stopwatch #(
	parameter int HOUR_LIMIT = uhs_pkg::HOUR_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  uhs_pkg::in_item_t  cmd_item,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output uhs_pkg::res_item_t result
);
	import uhs_pkg::*;

	op_item_t op_item;
	logic     op_empty;
	logic     op_pop;

	// decode and queue
	uhs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_item(cmd_item),
		.full    (full),
		.pop     (op_pop),
		.op_item (op_item),
		.empty   (op_empty)
	);

	// state update and result queue
	uhs_back #(
		.HOUR_LIMIT(HOUR_LIMIT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_empty(op_empty),
		.op_item (op_item),
		.op_pop  (op_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

### rtl/uhs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhs_checker
// port-level properties of the stopwatch, bound to the top level
// ----------------------------------------------------------------------------
`include "updown_hms_stopwatch_defines.svh"

module uhs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input uhs_pkg::res_item_t result
);
	import uhs_pkg::*;

	// a waiting result stays until it is taken
	`UHS_ASSERT_NEXT(a_res_held, clk, arst_n, !empty && !pop, !empty)

	// a waiting result does not change until it is taken
	`UHS_ASSERT_NEXT(a_res_stable, clk, arst_n, !empty && !pop, $stable(result))

	// a waiting result always shows a legal clock value
	`UHS_ASSERT_IMP(a_time_range, clk, arst_n, !empty, (result.minutes_now <= MS_MAX) && (result.seconds_now <= MS_MAX) && (result.hours_now <= 7'(HOUR_LIMIT_MAX)))

	// input back-pressure only comes from stalled results
	`UHS_ASSERT_IMP(a_full_backs_up, clk, arst_n, full, !empty)

endmodule

bind updown_hms_stopwatch uhs_checker u_uhs_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the up/down hh:mm:ss stopwatch: events go in
// through the input queue, a scoreboard keeps its own copy of the time,
// direction, run, alarm and press-mark state, and every result popped from
// the block is compared field by field against the predicted state
// ----------------------------------------------------------------------------
import uhs_pkg::*;

// adjust groups handled by one button pair each
typedef enum int {
	GRP_HOURS,
	GRP_MINUTES,
	GRP_SECONDS
} adj_group_e;

class hms_scoreboard;
	logic [6:0] hrs;
	logic [5:0] mins;
	logic [5:0] secs;
	logic       dir_up;
	logic       running;
	logic       alarm;
	logic [6:0] marks;
	res_item_t  expected_times[$];
	int         errors;

	function new();
		hrs = '0;
		mins = '0;
		secs = '0;
		dir_up = 1'b1;
		running = 1'b1;
		alarm = 1'b0;
		marks = '0;
		errors = 0;
	endfunction

	function int outstanding();
		return expected_times.size();
	endfunction

	// one minute up, carry into hours, hold at the hour limit
	function void add_minute();
		if (mins < MS_MAX) begin
			mins = mins + 1'b1;
		end else if (hrs < HOUR_LIMIT_DEF) begin
			mins = '0;
			hrs = hrs + 1'b1;
		end
	endfunction

	// one second up, carry all the way, hold at the top
	function void add_second();
		if (secs < MS_MAX) begin
			secs = secs + 1'b1;
		end else if (mins < MS_MAX || hrs < HOUR_LIMIT_DEF) begin
			secs = '0;
			add_minute();
		end
	endfunction

	// one second down with borrow, alarm at zero
	function void count_down();
		if (hrs == '0 && mins == '0 && secs == '0) begin
			alarm = 1'b1;
		end else begin
			alarm = 1'b0;
			if (secs != '0) begin
				secs = secs - 1'b1;
			end else begin
				secs = MS_MAX;
				if (mins != '0) begin
					mins = mins - 1'b1;
				end else begin
					mins = MS_MAX;
					hrs = hrs - 1'b1;
				end
			end
		end
	endfunction

	// dec beats inc, each press acts once until released
	function void adjust_group(logic [6:0] btn, int dec_bit, int inc_bit, adj_group_e grp);
		logic [6:0] val;
		case (grp)
			GRP_HOURS: val = hrs;
			GRP_MINUTES: val = 7'(mins);
			default: val = 7'(secs);
		endcase
		if (btn[dec_bit]) begin
			if (val != '0 && !marks[dec_bit]) begin
				case (grp)
					GRP_HOURS: hrs = hrs - 1'b1;
					GRP_MINUTES: mins = mins - 1'b1;
					default: secs = secs - 1'b1;
				endcase
				marks[dec_bit] = 1'b1;
			end
		end else if (btn[inc_bit]) begin
			if (!marks[inc_bit]) begin
				case (grp)
					GRP_HOURS: if (hrs < HOUR_LIMIT_DEF) hrs = hrs + 1'b1;
					GRP_MINUTES: add_minute();
					default: add_second();
				endcase
				marks[inc_bit] = 1'b1;
			end
		end else begin
			marks[dec_bit] = 1'b0;
			marks[inc_bit] = 1'b0;
		end
	endfunction

	// accepted event: update the state and queue the result it gives
	function void note_event(in_item_t it);
		res_item_t want;
		case (it.cmd)
			CMD_TICK: begin
				if (running) begin
					if (dir_up) begin
						alarm = 1'b0;
						add_second();
					end else begin
						count_down();
					end
				end
			end
			CMD_RESET: begin
				hrs = '0;
				mins = '0;
				secs = '0;
				dir_up = 1'b1;
				alarm = 1'b0;
			end
			CMD_PAUSE: running = 1'b0;
			CMD_RESUME: running = 1'b1;
			CMD_BUTTONS: begin
				if (!running) begin
					adjust_group(it.buttons, BTN_HDEC, BTN_HINC, GRP_HOURS);
					adjust_group(it.buttons, BTN_MDEC, BTN_MINC, GRP_MINUTES);
					adjust_group(it.buttons, BTN_SDEC, BTN_SINC, GRP_SECONDS);
					if (it.buttons[BTN_MODE]) begin
						if (!marks[BTN_MODE]) begin
							dir_up = ~dir_up;
							marks[BTN_MODE] = 1'b1;
						end
					end else begin
						marks[BTN_MODE] = 1'b0;
					end
				end
			end
			default: ;
		endcase
		want.hours_now = hrs;
		want.minutes_now = mins;
		want.seconds_now = secs;
		want.counting_up = dir_up;
		want.is_running = running;
		want.alarm_on = alarm;
		expected_times.push_back(want);
	endfunction

	function void check_field(string name, logic [6:0] want, logic [6:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// popped result against the oldest pending state
	function void check_result(res_item_t got);
		res_item_t want;
		if (expected_times.size() == 0) begin
			$error("result popped with no item pending");
			errors++;
			return;
		end
		want = expected_times.pop_front();
		check_field("hours_now", 7'(want.hours_now), 7'(got.hours_now));
		check_field("minutes_now", 7'(want.minutes_now), 7'(got.minutes_now));
		check_field("seconds_now", 7'(want.seconds_now), 7'(got.seconds_now));
		check_field("counting_up", 7'(want.counting_up), 7'(got.counting_up));
		check_field("is_running", 7'(want.is_running), 7'(got.is_running));
		check_field("alarm_on", 7'(want.alarm_on), 7'(got.alarm_on));
	endfunction
endclass

module tb_top;
	localparam int CLK_HALF = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int EVENT_BUDGET = 1100;
	localparam int IDLE_PCT = 27;
	localparam int TAIL_CYCLES = 10;
	localparam logic [2:0] CMD_TOP = '1;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      pop = 1'b0;
	in_item_t  cmd_item = '0;
	logic      full;
	logic      empty;
	res_item_t result;

	hms_scoreboard hms_board = new();
	int sent_events = 0;
	int cycle_count = 0;
	bit calm = 1'b0;
	int rx_hold_cycles = 0;

	updown_hms_stopwatch uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.cmd_item(cmd_item),
		.full(full),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	// clock
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// watch both handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) hms_board.note_event(cmd_item);
			if (pop && !empty) hms_board.check_result(result);
		end
	end

	// result side: random pop, with one long hold-off on request
	initial begin : result_drain
		int span;
		wait (arst_n);
		forever begin
			if (rx_hold_cycles > 0) begin
				span = rx_hold_cycles;
				rx_hold_cycles = 0;
				pop <= 1'b0;
				repeat (span) @(posedge clk);
			end else begin
				pop <= calm || ($urandom_range(99) >= IDLE_PCT);
				@(posedge clk);
			end
		end
	end

	function automatic logic [6:0] button_mask(int bit_pos);
		return 7'(1) << bit_pos;
	endfunction

	// offer one item, optionally after a random gap, and wait until taken
	task automatic send_event(input logic [2:0] cmd, input logic [6:0] btn);
		in_item_t it;
		it.cmd = cmd;
		it.buttons = btn;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		cmd_item <= it;
		do @(posedge clk); while (full);
		sent_events++;
	endtask

	task automatic press_release(input logic [6:0] btn);
		send_event(CMD_BUTTONS, btn);
		send_event(CMD_BUTTONS, '0);
	endtask

	task automatic pause_until_drained();
		push <= 1'b0;
		do @(posedge clk); while (hms_board.outstanding() != 0);
	endtask

	// climb to the hour limit, borrow down through an hour, then sit at the top
	task automatic wind_to_top();
		send_event(CMD_RESET, '0);
		send_event(CMD_PAUSE, '0);
		send_event(CMD_BUTTONS, '0);
		repeat (HOUR_LIMIT_DEF + 1) press_release(button_mask(BTN_HINC));
		press_release(button_mask(BTN_MODE));
		send_event(CMD_RESUME, '0);
		send_event(CMD_TICK, '0);
		send_event(CMD_PAUSE, '0);
		press_release(button_mask(BTN_HINC));
		press_release(button_mask(BTN_MODE));
		press_release(button_mask(BTN_SINC));
		press_release(button_mask(BTN_MINC));
		press_release(button_mask(BTN_HINC));
		send_event(CMD_RESUME, '0);
		repeat (3) send_event(CMD_TICK, 7'($urandom_range(127)));
	endtask

	initial begin : stimulus
		logic [2:0] c;
		logic [6:0] b;
		int n;
		int k;
		int pick;
		bit held_off;
		bit drained;
		held_off = 1'b0;
		drained = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: run/pause edges, all buttons, dec over inc, countdown to alarm
		send_event(CMD_TICK, '0);
		send_event(CMD_RESUME, '1);
		send_event(CMD_PAUSE, '0);
		send_event(CMD_PAUSE, '1);
		send_event(CMD_TICK, '1);
		send_event(CMD_BUTTONS, '1);
		send_event(CMD_BUTTONS, '1);
		send_event(CMD_BUTTONS, '0);
		b = button_mask(BTN_HINC) | button_mask(BTN_MINC) | button_mask(BTN_SINC);
		send_event(CMD_BUTTONS, b);
		press_release(b);
		press_release(button_mask(BTN_HDEC) | button_mask(BTN_MDEC) | button_mask(BTN_MINC));
		send_event(CMD_RESUME, '0);
		repeat (3) send_event(CMD_TICK, '0);
		send_event(CMD_BUTTONS, '1);
		c = CMD_BUTTONS;
		do begin
			c = c + 1'b1;
			send_event(c, 7'($urandom_range(127)));
		end while (c != CMD_TOP);
		send_event(CMD_RESET, '1);
		send_event(CMD_TICK, '0);

		wind_to_top();

		// random sessions
		while (sent_events < EVENT_BUDGET) begin
			calm = (sent_events >= 600 && sent_events < 750);
			if (!held_off && sent_events >= 450) begin
				held_off = 1'b1;
				rx_hold_cycles = 80;
			end
			if (!drained && sent_events >= 900) begin
				drained = 1'b1;
				pause_until_drained();
				wind_to_top();
			end
			pick = $urandom_range(99);
			if (pick < 40) begin
				// paused adjust with press/release patterns
				send_event(CMD_PAUSE, 7'($urandom_range(127)));
				n = $urandom_range(24, 4);
				repeat (n) begin
					b = '0;
					if ($urandom_range(9) < 2) begin
						b = 7'($urandom_range(127));
					end else if ($urandom_range(9) >= 4) begin
						for (k = 0; k < 7; k++) b[k] = ($urandom_range(99) < 25);
					end
					send_event(CMD_BUTTONS, b);
				end
				if ($urandom_range(9) < 7) send_event(CMD_RESUME, 7'($urandom_range(127)));
			end else if (pick < 75) begin
				// run of ticks, a stray event now and then
				if ($urandom_range(1) == 1) send_event(CMD_RESUME, 7'($urandom_range(127)));
				n = $urandom_range(70, 1);
				repeat (n) begin
					if ($urandom_range(19) == 0)
						send_event(3'($urandom_range(7)), 7'($urandom_range(127)));
					else
						send_event(CMD_TICK, 7'($urandom_range(127)));
				end
			end else if (pick < 90) begin
				repeat ($urandom_range(5, 1))
					send_event(3'($urandom_range(7)), 7'($urandom_range(127)));
			end else begin
				send_event(CMD_RESET, 7'($urandom_range(127)));
			end
		end

		// wind down
		calm = 1'b0;
		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (hms_board.errors == 0 && hms_board.outstanding() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
